@@ design/tlbr_pkg.sv @@
package tlbr_pkg;

  // sizes of the packet fields
  localparam int unsigned MaxBytesDef = 256;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned LenW        = 9;
  localparam int unsigned BitCntW     = 12;

  // stream beat widths
  localparam int unsigned InTuserW  = 3;
  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 40;

  // radio packet format
  localparam logic [ByteW-1:0] RadioId      = 8'hF0;
  localparam logic [LenW-1:0]  RadioLastIdx = 9'd17;
  // handshaked mode takes its length from byte 1 plus this
  localparam logic [LenW-1:0]  HsLenAdd     = 9'd2;

  // bus event codes
  typedef enum logic [2:0] {
    REQ_ENA_RISE = 3'd0,
    REQ_CLK_FALL = 3'd1,
    REQ_ENA_FALL = 3'd2,
    REQ_REQUEST  = 3'd3,
    REQ_READ     = 3'd4
  } req_e;

  // enable line actions
  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_ACK         = 3'd1,
    ACT_RELEASE     = 3'd2,
    ACT_NAVI_START  = 3'd3,
    ACT_REQ_PULSE   = 3'd4
  } act_e;

  // receive mode
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RX   = 2'd1,
    MODE_HS   = 2'd2
  } mode_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_RMW   = 3'd2,
    ST_RDB   = 3'd3,
    ST_WALK  = 3'd4,
    ST_FIN_A = 3'd5,
    ST_FIN_B = 3'd6,
    ST_FIN_C = 3'd7
  } state_e;

  // read request from the checksum walker
  typedef struct packed {
    logic            en;
    logic [LenW-1:0] idx;
  } rd_req_t;

  // checksum walk outcome
  typedef struct packed {
    logic valid;
    logic ok;
    logic navi;
  } walk_res_t;

endpackage

@@ design/three_line_bus_packet_receiver_core.sv @@
// channel    | dir | tuser (lsb up)  | tdata (lsb up)
// s_axis     | in  | req_type[2:0]   | data_level[0], ena_level[1], byte_index[9:2]
// m_axis     | out | -               | ena_action[2:0], msg_ready[3], is_navi[4],
//            |     |                 | packet_length[13:5], read_byte[21:14],
//            |     |                 | msg_id[29:22], check_byte[37:30], accepted[38]
//
// one beat at a time: an event runs ST_FIN_A, ST_FIN_B and ST_FIN_C, a clock fall
// or a byte read runs ST_RMW or ST_RDB before them, a packet check the checksum
// walk, which reads the byte store one byte per cycle through its single read port
// after reset a clearing pass writes zeros to all MAX_BYTES entries, one per
// cycle, with s_axis_tready low; a stalled result sits in the output register
// while the next event is already taken
module three_line_bus_packet_receiver_core #(
  parameter int unsigned MAX_BYTES = tlbr_pkg::MaxBytesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // data_level, ena_level, byte_index
  input  logic [tlbr_pkg::InTdataW-1:0]   s_axis_tdata,
  // req_type
  input  logic [tlbr_pkg::InTuserW-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // ena_action, msg_ready, is_navi, packet_length, read_byte, msg_id,
  // check_byte, accepted
  output logic [tlbr_pkg::OutTdataW-1:0]  m_axis_tdata
);

  localparam int unsigned AW = $clog2(MAX_BYTES);

  tlbr_pkg::state_e               state_q, state_d;
  tlbr_pkg::mode_e                mode_q, mode_d;
  logic [tlbr_pkg::BitCntW-1:0]   bit_cnt_q, bit_cnt_d;
  logic                           ready_q, ready_d;
  logic                           navi_q, navi_d;
  logic [tlbr_pkg::LenW-1:0]      len_q, len_d;
  logic [AW-1:0]                  clr_idx_q, clr_idx_d;
  logic                           out_valid_q, out_valid_d;

  tlbr_pkg::act_e                 act_q, act_d;
  logic                           acc_q, acc_d;
  logic [tlbr_pkg::ByteW-1:0]     rbyte_q, rbyte_d;
  logic [tlbr_pkg::ByteW-1:0]     byte0_q, byte0_d;
  logic                           dlev_q, dlev_d;
  logic                           rdb_inr_q, rdb_inr_d;
  logic                           chk_inr_q, chk_inr_d;
  logic [tlbr_pkg::OutTdataW-1:0] out_data_q, out_data_d;

  logic                           in_accept;
  tlbr_pkg::req_e                 in_req;
  logic                           in_dlev;
  logic                           in_elev;
  logic [tlbr_pkg::ByteW-1:0]     in_idx;

  logic [tlbr_pkg::LenW-1:0]      bi;
  logic                           bi_inr;
  logic [tlbr_pkg::ByteW-1:0]     new_byte;
  logic [tlbr_pkg::LenW-1:0]      len_eff;
  logic [tlbr_pkg::LenW-1:0]      len_m1;
  logic [tlbr_pkg::LenW-1:0]      fall_len;

  logic                           fsm_re;
  logic [AW-1:0]                  fsm_raddr;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [tlbr_pkg::ByteW-1:0]     ram_wdata;
  logic [tlbr_pkg::ByteW-1:0]     ram_rdata;

  logic                           walk_start;
  logic [tlbr_pkg::LenW-1:0]      walk_last;
  tlbr_pkg::rd_req_t              walk_rd;
  tlbr_pkg::walk_res_t            walk_res;

  // input beat fields
  assign s_axis_tready = (state_q == tlbr_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_req        = tlbr_pkg::req_e'(s_axis_tuser);
  assign in_dlev       = s_axis_tdata[0];
  assign in_elev       = s_axis_tdata[1];
  assign in_idx        = s_axis_tdata[9:2];

  // byte addressed by the bit counter, and derived lengths
  assign bi       = bit_cnt_q[tlbr_pkg::BitCntW-1:3];
  assign bi_inr   = ({1'b0, bi} < 10'(MAX_BYTES));
  assign new_byte = {ram_rdata[tlbr_pkg::ByteW-2:0], ~dlev_q};
  assign len_eff  = (bit_cnt_q == 12'd15) ? ({1'b0, new_byte} + tlbr_pkg::HsLenAdd) : len_q;
  assign len_m1   = len_q - 9'd1;
  assign fall_len = bit_cnt_q[tlbr_pkg::BitCntW-1:3];

  // byte store read port shared between sequencer and walker
  assign ram_re    = (state_q == tlbr_pkg::ST_WALK) ? walk_rd.en : fsm_re;
  assign ram_raddr = (state_q == tlbr_pkg::ST_WALK) ? walk_rd.idx[AW-1:0] : fsm_raddr;

  tlbr_ram #(
    .Width (tlbr_pkg::ByteW),
    .Depth (MAX_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tlbr_walk #(
    .MAX_BYTES (MAX_BYTES)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (walk_start),
    .last_idx_i (walk_last),
    .rdata_i    (ram_rdata),
    .rd_o       (walk_rd),
    .res_o      (walk_res)
  );

  // sequencer: store clear, event decode, read-modify-write, checksum walk, result build
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    bit_cnt_d   = bit_cnt_q;
    ready_d     = ready_q;
    navi_d      = navi_q;
    len_d       = len_q;
    clr_idx_d   = clr_idx_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    act_d       = act_q;
    acc_d       = acc_q;
    rbyte_d     = rbyte_q;
    byte0_d     = byte0_q;
    dlev_d      = dlev_q;
    rdb_inr_d   = rdb_inr_q;
    chk_inr_d   = chk_inr_q;
    out_data_d  = out_data_q;
    fsm_re      = 1'b0;
    fsm_raddr   = '0;
    ram_we      = 1'b0;
    ram_waddr   = bi[AW-1:0];
    ram_wdata   = new_byte;
    walk_start  = 1'b0;
    walk_last   = '0;

    unique case (state_q)
      tlbr_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        ram_wdata = '0;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == AW'(MAX_BYTES - 1)) begin
          state_d = tlbr_pkg::ST_IDLE;
        end
      end

      tlbr_pkg::ST_IDLE: begin
        if (in_accept) begin
          act_d   = tlbr_pkg::ACT_NONE;
          acc_d   = 1'b0;
          rbyte_d = '0;
          dlev_d  = in_dlev;
          state_d = tlbr_pkg::ST_FIN_A;
          unique case (in_req)
            tlbr_pkg::REQ_ENA_RISE: begin
              if (mode_q == tlbr_pkg::MODE_IDLE) begin
                bit_cnt_d = '0;
                ready_d   = 1'b0;
                navi_d    = 1'b0;
                mode_d    = tlbr_pkg::MODE_RX;
              end
            end
            tlbr_pkg::REQ_CLK_FALL: begin
              if (mode_q == tlbr_pkg::MODE_RX || mode_q == tlbr_pkg::MODE_HS) begin
                fsm_re    = bi_inr;
                fsm_raddr = bi[AW-1:0];
                state_d   = tlbr_pkg::ST_RMW;
              end
            end
            tlbr_pkg::REQ_ENA_FALL: begin
              if (mode_q == tlbr_pkg::MODE_RX) begin
                len_d = '0;
                if (bit_cnt_q != '0) begin
                  if (fall_len > 9'd1) begin
                    len_d      = fall_len;
                    mode_d     = tlbr_pkg::MODE_IDLE;
                    walk_start = 1'b1;
                    walk_last  = fall_len - 9'd1;
                    state_d    = tlbr_pkg::ST_WALK;
                  end else begin
                    mode_d = tlbr_pkg::MODE_HS;
                    act_d  = tlbr_pkg::ACT_NAVI_START;
                  end
                end else begin
                  mode_d = tlbr_pkg::MODE_IDLE;
                end
              end
            end
            tlbr_pkg::REQ_REQUEST: begin
              if (!in_elev) begin
                acc_d  = 1'b1;
                act_d  = tlbr_pkg::ACT_REQ_PULSE;
                mode_d = tlbr_pkg::MODE_IDLE;
              end
            end
            tlbr_pkg::REQ_READ: begin
              rdb_inr_d = ({2'b00, in_idx} < 10'(MAX_BYTES));
              fsm_re    = rdb_inr_d;
              fsm_raddr = AW'({1'b0, in_idx});
              state_d   = tlbr_pkg::ST_RDB;
            end
            default: begin
              // unknown event: status only
            end
          endcase
        end
      end

      tlbr_pkg::ST_RDB: begin
        rbyte_d = rdb_inr_q ? ram_rdata : '0;
        state_d = tlbr_pkg::ST_FIN_A;
      end

      tlbr_pkg::ST_RMW: begin
        // shift the new bit into the addressed byte
        ram_we    = bi_inr;
        ready_d   = 1'b0;
        bit_cnt_d = bit_cnt_q + 12'd1;
        state_d   = tlbr_pkg::ST_FIN_A;
        if (mode_q == tlbr_pkg::MODE_HS && bit_cnt_q[2:0] == 3'b111) begin
          len_d = len_eff;
          if (({1'b0, bit_cnt_q} + 13'd1) != {1'b0, len_eff, 3'b000}) begin
            act_d = tlbr_pkg::ACT_ACK;
          end else begin
            act_d      = tlbr_pkg::ACT_RELEASE;
            mode_d     = tlbr_pkg::MODE_IDLE;
            bit_cnt_d  = '0;
            walk_start = 1'b1;
            walk_last  = len_eff - 9'd1;
            state_d    = tlbr_pkg::ST_WALK;
          end
        end
      end

      tlbr_pkg::ST_WALK: begin
        if (walk_res.valid) begin
          if (walk_res.ok) begin
            ready_d = 1'b1;
          end
          navi_d  = walk_res.navi;
          state_d = tlbr_pkg::ST_FIN_A;
        end
      end

      tlbr_pkg::ST_FIN_A: begin
        fsm_re    = 1'b1;
        fsm_raddr = '0;
        state_d   = tlbr_pkg::ST_FIN_B;
      end

      tlbr_pkg::ST_FIN_B: begin
        byte0_d   = ram_rdata;
        chk_inr_d = (len_q != '0) && ({1'b0, len_m1} < 10'(MAX_BYTES));
        fsm_re    = chk_inr_d;
        fsm_raddr = len_m1[AW-1:0];
        state_d   = tlbr_pkg::ST_FIN_C;
      end

      tlbr_pkg::ST_FIN_C: begin
        // wait for the output register to free up
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, acc_q, (chk_inr_q ? ram_rdata : 8'h00), byte0_q,
                         rbyte_q, len_q, navi_q, ready_q, act_q};
          state_d     = tlbr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tlbr_pkg::ST_IDLE;
      end
    endcase
  end

  // control and packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlbr_pkg::ST_CLEAR;
      mode_q      <= tlbr_pkg::MODE_IDLE;
      bit_cnt_q   <= '0;
      ready_q     <= 1'b0;
      navi_q      <= 1'b0;
      len_q       <= '0;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      bit_cnt_q   <= bit_cnt_d;
      ready_q     <= ready_d;
      navi_q      <= navi_d;
      len_q       <= len_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    acc_q      <= acc_d;
    rbyte_q    <= rbyte_d;
    byte0_q    <= byte0_d;
    dlev_q     <= dlev_d;
    rdb_inr_q  <= rdb_inr_d;
    chk_inr_q  <= chk_inr_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ design/tlbr_ram.sv @@
module tlbr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port; read data holds without re
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/tlbr_walk.sv @@
module tlbr_walk #(
  parameter int unsigned MAX_BYTES = tlbr_pkg::MaxBytesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tlbr_pkg::LenW-1:0]       last_idx_i,
  input  logic [tlbr_pkg::ByteW-1:0]      rdata_i,
  output tlbr_pkg::rd_req_t               rd_o,
  output tlbr_pkg::walk_res_t             res_o
);

  logic                         issue_q, issue_d;
  logic [tlbr_pkg::LenW-1:0]    idx_q, idx_d;
  logic [tlbr_pkg::LenW-1:0]    last_q, last_d;
  logic                         beat_v_q, beat_v_d;
  logic                         beat_last_q;
  logic                         beat_inr_q;
  logic [tlbr_pkg::ByteW-1:0]   sum_q, sum_d;
  logic [tlbr_pkg::ByteW-1:0]   xor_q, xor_d;
  logic [tlbr_pkg::ByteW-1:0]   byte0_q, byte0_d;
  logic                         first_q, first_d;
  tlbr_pkg::walk_res_t          res_q, res_d;
  logic                         idx_inr;
  logic [tlbr_pkg::ByteW-1:0]   beat;
  logic [tlbr_pkg::ByteW-1:0]   b0;
  logic                         radio;
  logic                         ok;

  // bytes beyond the store read as zero
  assign idx_inr = ({1'b0, idx_q} < 10'(MAX_BYTES));
  assign beat    = beat_inr_q ? rdata_i : '0;
  assign b0      = first_q ? beat : byte0_q;
  assign radio   = (last_q == tlbr_pkg::RadioLastIdx) && (b0 == tlbr_pkg::RadioId);

  // inverted sum for radio packets, nonzero xor minus one otherwise
  always_comb begin
    if (radio) begin
      ok = (beat == ~sum_q);
    end else begin
      ok = (xor_q != '0) && (beat == (xor_q - 8'd1));
    end
  end

  assign rd_o.en  = issue_q && idx_inr;
  assign rd_o.idx = idx_q;
  assign res_o    = res_q;

  // address issue and accumulation
  always_comb begin
    issue_d  = issue_q;
    idx_d    = idx_q;
    last_d   = last_q;
    sum_d    = sum_q;
    xor_d    = xor_q;
    byte0_d  = byte0_q;
    first_d  = first_q;
    beat_v_d = issue_q && !start_i;
    res_d    = '0;
    if (start_i) begin
      issue_d = 1'b1;
      idx_d   = '0;
      last_d  = last_idx_i;
      sum_d   = '0;
      xor_d   = '0;
      first_d = 1'b1;
    end else begin
      if (issue_q) begin
        idx_d = idx_q + 9'd1;
        if (idx_q == last_q) begin
          issue_d = 1'b0;
        end
      end
      if (beat_v_q) begin
        if (beat_last_q) begin
          res_d.valid = 1'b1;
          res_d.ok    = ok;
          res_d.navi  = !radio;
        end else begin
          sum_d   = sum_q + beat;
          xor_d   = xor_q ^ beat;
          first_d = 1'b0;
          if (first_q) begin
            byte0_d = beat;
          end
        end
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q  <= 1'b0;
      beat_v_q <= 1'b0;
      res_q    <= '0;
    end else begin
      issue_q  <= issue_d;
      beat_v_q <= beat_v_d;
      res_q    <= res_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    last_q      <= last_d;
    sum_q       <= sum_d;
    xor_q       <= xor_d;
    byte0_q     <= byte0_d;
    first_q     <= first_d;
    beat_last_q <= (idx_q == last_q);
    beat_inr_q  <= idx_inr;
  end

endmodule

@@ design/tlbr_checker.sv @@
module tlbr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tlbr_pkg::OutTdataW-1:0]  m_axis_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // one event in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an event is in work");

  // accepted flag goes with the request pulse
  a_accept_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[38] == (m_axis_tdata[2:0] == tlbr_pkg::ACT_REQ_PULSE)))
    else $error("accepted flag without request pulse");

  // a byte ack comes mid-packet, with ready cleared
  a_ack_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] == tlbr_pkg::ACT_ACK) |-> !m_axis_tdata[3])
    else $error("byte ack with message ready set");

  // entering handshaked mode clears the length
  a_navi_start_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] == tlbr_pkg::ACT_NAVI_START) |->
      (m_axis_tdata[13:5] == 9'd0))
    else $error("navi start pulse with nonzero length");

endmodule

bind three_line_bus_packet_receiver_core tlbr_checker u_tlbr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
